FILE: rtl/core/hung_note_release_resolver_defines.svh
// Assertion macros for the hung note release resolver checks.
// Used by the port checker; expects clk and arst_n in scope.
`ifndef HUNG_NOTE_RELEASE_RESOLVER_DEFINES_SVH
`define HUNG_NOTE_RELEASE_RESOLVER_DEFINES_SVH

// same-cycle implication
`define HNRR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HNRR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/hnrr_pkg.sv
// Shared types and constants of the hung note release resolver.
// No dependencies; imported by hnrr_ctrl, hnrr_dp and the top level.
`default_nettype none
package hnrr_pkg;

	typedef enum logic [2:0] {
		OP_HOLD_NOTE  = 3'd0,
		OP_HOLD_PEDAL = 3'd1,
		OP_BEGIN      = 3'd2,
		OP_EVENT      = 3'd3,
		OP_READ       = 3'd4,
		OP_CLEAR_HELD = 3'd5
	} op_t;

	localparam logic [1:0] REG_LOOP_LENGTH = 2'd0;
	localparam logic [1:0] REG_SCAN_LIMIT  = 2'd1;

	localparam logic [7:0] CH_MASK       = 8'h0f;
	localparam logic [7:0] KIND_MASK     = 8'hf0;
	localparam logic [7:0] KIND_NOTE_ON  = 8'h90;
	localparam logic [7:0] KIND_NOTE_OFF = 8'h80;
	localparam logic [7:0] KIND_CTRL     = 8'hb0;
	localparam logic [7:0] DATA_MASK     = 8'h7f;
	localparam logic [7:0] CTRL_SUSTAIN  = 8'd64;

	localparam int PLAYHEAD_W = 40;
	localparam int PULSE_W    = 24;
	localparam int LOOP_W     = 24;
	localparam int LIMIT_W    = 16;
	localparam int WAIT_W     = 12;
	localparam int READS_W    = 17;
	localparam int START_W    = 25;
	localparam int FRAC_W     = 16;
	localparam int ROW_BITS   = 64;
	localparam int CFG_W      = 24;
	localparam int CFG_IDX_W  = 2;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1024;

	typedef struct packed {
		logic load;
		logic dec;
		logic rmw;
		logic mul;
		logic div_init;
		logic div_step;
		logic fix;
		logic sw_rd;
		logic sw_wr;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic is_begin;
		logic need_rmw;
		logic div_last;
		logic sw_last;
	} sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/hnrr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module hnrr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/core/hnrr_ctrl.sv
// Controller state machine of the resolver: sequences the datapath.
// Depends on hnrr_pkg (cmd_t, sts_t).
`default_nettype none
module hnrr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	output logic               done,
	output hnrr_pkg::cmd_t     cmd,
	input  wire hnrr_pkg::sts_t sts
);
	import hnrr_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_DEC  = 11'b000_0000_0010,
		S_RMW  = 11'b000_0000_0100,
		S_MUL  = 11'b000_0000_1000,
		S_DIVI = 11'b000_0001_0000,
		S_DIV  = 11'b000_0010_0000,
		S_FIX  = 11'b000_0100_0000,
		S_SWRD = 11'b000_1000_0000,
		S_SWWR = 11'b001_0000_0000,
		S_FIN  = 11'b010_0000_0000,
		S_OUT  = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = start;
				if (start) state_d = S_DEC;
			end
			S_DEC: begin
				cmd.dec = 1'b1;
				if (sts.is_begin) state_d = S_MUL;
				else if (sts.need_rmw) state_d = S_RMW;
				else state_d = S_OUT;
			end
			S_RMW: begin
				cmd.rmw = 1'b1;
				state_d = S_OUT;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DIVI;
			end
			S_DIVI: begin
				cmd.div_init = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = S_FIX;
			end
			S_FIX: begin
				cmd.fix = 1'b1;
				state_d = S_SWRD;
			end
			S_SWRD: begin
				cmd.sw_rd = 1'b1;
				state_d = S_SWWR;
			end
			S_SWWR: begin
				cmd.sw_wr = 1'b1;
				state_d = sts.sw_last ? S_FIN : S_SWRD;
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_OUT);
endmodule
`default_nettype wire

FILE: rtl/core/hnrr_dp.sv
// Datapath of the resolver: bitmap RAMs, pedal bits, scan counters,
// playhead multiply and remainder unit. Depends on hnrr_pkg and hnrr_ram.
`default_nettype none
module hnrr_dp #(
	parameter int CHANNELS           = 16,
	parameter int KEYS               = 128,
	parameter int PULSES_PER_QUARTER = 960
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire hnrr_pkg::cmd_t                      cmd,
	output hnrr_pkg::sts_t                           sts,
	input  wire logic [2:0]                          op,
	input  wire logic [3:0]                          channel,
	input  wire logic [6:0]                          key,
	input  wire logic                                half,
	input  wire logic signed [hnrr_pkg::PLAYHEAD_W-1:0] playhead,
	input  wire logic [hnrr_pkg::PULSE_W-1:0]        event_pulse,
	input  wire logic [7:0]                          status,
	input  wire logic [7:0]                          data_one,
	input  wire logic [7:0]                          data_two,
	input  wire logic                                cfg_we,
	input  wire logic [hnrr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [hnrr_pkg::CFG_W-1:0]          cfg_data,
	output logic [hnrr_pkg::ROW_BITS-1:0]            release_mask,
	output logic                                     pedal_release,
	output logic [hnrr_pkg::WAIT_W-1:0]              waiting_left,
	output logic                                     scan_done,
	output logic                                     settled_now
);
	import hnrr_pkg::*;

	localparam int ROWS   = 2 * CHANNELS;
	localparam int ROW_W  = $clog2(ROWS);
	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PPQ_W  = $clog2(PULSES_PER_QUARTER + 1);
	localparam int PROD_W = PLAYHEAD_W + PPQ_W + 1;
	localparam int Q_W    = PROD_W - FRAC_W;
	localparam int CNT_W  = $clog2(Q_W);
	localparam logic signed [PROD_W-1:0] PPQ_S = PROD_W'(PULSES_PER_QUARTER);
	localparam logic [START_W-1:0] START_SAT = START_W'(1) << PULSE_W;

	// latched item
	logic [2:0]                    op_q;
	logic [3:0]                    ch_q;
	logic [6:0]                    key_q;
	logic                          half_q;
	logic signed [PLAYHEAD_W-1:0]  ph_q;
	logic [PULSE_W-1:0]            pulse_q;
	logic [7:0]                    stat_q, d1_q, d2_q;

	// configuration and scan state
	logic [LOOP_W-1:0]   loop_q;
	logic [LIMIT_W-1:0]  limit_q;
	logic [ROWS-1:0]     held_vld_q, drop_vld_q, set_vld_q;
	logic [CHANNELS-1:0] held_ped_q, drop_ped_q, set_ped_q;
	logic [START_W-1:0]  start_q;
	logic [WAIT_W-1:0]   wait_q;
	logic [READS_W-1:0]  reads_q;
	logic                over_q;
	logic [ROW_BITS-1:0] mask_q;
	logic                pedal_q, now_q;
	logic [ROW_W-1:0]    sw_q;
	logic [CNT_W-1:0]    cnt_q;

	// remainder unit
	logic signed [PROD_W-1:0] prod_q;
	logic [Q_W-1:0]           mag_q;
	logic [LOOP_W-1:0]        rem_q;
	logic                     neg_q;

	// decode
	logic [3:0]          ev_ch;
	logic [7:0]          kind, ev_key;
	logic                ch_ok, key_ok, ev_ch_ok, ev_key_ok;
	logic                note_cls, ped_cls, ev_go, lim_hit, clr_note;
	logic                need_rmw;
	logic [READS_W-1:0]  reads_nx;
	logic [CH_W-1:0]     chi, evi;
	logic [ROW_W-1:0]    row_sel, rd_idx, raddr;
	logic [5:0]          bit_sel;
	logic [ROW_BITS-1:0] bit_m;
	logic [ROW_BITS-1:0] held_rd, drop_rd, set_rd;
	logic [ROW_BITS-1:0] held_row, drop_row, set_row;
	logic                pend_note, ped_pend;
	logic [WAIT_W-1:0]   wait_dec;

	// remainder and threshold
	logic signed [Q_W-1:0] quo;
	logic [LOOP_W:0]       rem2;
	logic                  frac_nz;
	logic [Q_W:0]          ceil_sum;
	logic [LOOP_W-1:0]     rem_fix;
	logic [START_W-1:0]    start_nx;

	// RAM ports
	logic                held_we, drop_we, set_we;
	logic [ROW_W-1:0]    drop_waddr;
	logic [ROW_BITS-1:0] drop_wdata;

	assign ev_ch     = stat_q[3:0] & CH_MASK[3:0];
	assign kind      = stat_q & KIND_MASK;
	assign ev_key    = d1_q & DATA_MASK;
	assign ch_ok     = (5'(ch_q) < 5'(CHANNELS));
	assign key_ok    = (8'(key_q) < 8'(KEYS));
	assign ev_ch_ok  = (5'(ev_ch) < 5'(CHANNELS));
	assign ev_key_ok = (ev_key < 8'(KEYS));
	assign note_cls  = ev_ch_ok && ((kind == KIND_NOTE_ON) || (kind == KIND_NOTE_OFF));
	assign ped_cls   = ev_ch_ok && (kind == KIND_CTRL) && (ev_key == CTRL_SUSTAIN);
	assign clr_note  = (kind == KIND_NOTE_OFF) || (d2_q == 8'd0);
	assign ev_go     = !over_q && ({1'b0, pulse_q} >= start_q);
	assign reads_nx  = reads_q + READS_W'(1);
	assign lim_hit   = (reads_nx > READS_W'(limit_q));
	assign chi       = ch_q[CH_W-1:0];
	assign evi       = ev_ch[CH_W-1:0];

	always_comb begin
		case (op_q)
			OP_EVENT: begin
				row_sel = ROW_W'({ev_ch, ev_key[6]});
				bit_sel = ev_key[5:0];
			end
			OP_READ: begin
				row_sel = ROW_W'({ch_q, half_q});
				bit_sel = key_q[5:0];
			end
			default: begin
				row_sel = ROW_W'({ch_q, key_q[6]});
				bit_sel = key_q[5:0];
			end
		endcase
	end

	assign bit_m     = ROW_BITS'(1) << bit_sel;
	assign rd_idx    = cmd.sw_wr ? sw_q : row_sel;
	assign raddr     = cmd.sw_rd ? sw_q : row_sel;
	assign held_row  = held_rd & {ROW_BITS{held_vld_q[rd_idx]}};
	assign drop_row  = drop_rd & {ROW_BITS{drop_vld_q[rd_idx]}};
	assign set_row   = set_rd & {ROW_BITS{set_vld_q[rd_idx]}};
	assign pend_note = (|(drop_row & bit_m)) && !(|(set_row & bit_m));
	assign ped_pend  = drop_ped_q[evi] && !set_ped_q[evi];
	assign wait_dec  = (wait_q != '0) ? (wait_q - WAIT_W'(1)) : wait_q;

	always_comb begin
		case (op_q)
			OP_HOLD_NOTE: need_rmw = ch_ok && key_ok;
			OP_READ:      need_rmw = ch_ok;
			OP_EVENT:     need_rmw = ev_go && !lim_hit && note_cls && ev_key_ok;
			default:      need_rmw = 1'b0;
		endcase
	end
	assign sts.need_rmw = need_rmw;
	assign sts.is_begin = (op_q == OP_BEGIN);
	assign sts.div_last = (cnt_q == '0);
	assign sts.sw_last  = (sw_q == ROW_W'(ROWS - 1));

	// threshold from product: floor quotient by 2^16 and fraction
	assign quo      = prod_q[PROD_W-1:FRAC_W];
	assign frac_nz  = |prod_q[FRAC_W-1:0];
	assign rem2     = {rem_q, mag_q[Q_W-1]};
	assign ceil_sum = {1'b0, quo} + (Q_W+1)'(frac_nz);
	assign rem_fix  = (neg_q && (rem_q != '0)) ? (loop_q - rem_q) : rem_q;

	always_comb begin
		if (loop_q == '0) begin
			if (prod_q[PROD_W-1] || (prod_q == '0)) begin
				start_nx = '0;
			end else if (ceil_sum > (Q_W+1)'(START_SAT)) begin
				start_nx = START_SAT;
			end else begin
				start_nx = ceil_sum[START_W-1:0];
			end
		end else begin
			start_nx = START_W'(rem_fix) + START_W'(frac_nz);
		end
	end

	// RAM write control
	assign held_we    = cmd.rmw && (op_q == OP_HOLD_NOTE);
	assign set_we     = cmd.rmw && (op_q == OP_EVENT) && pend_note;
	assign drop_we    = cmd.sw_wr || (set_we && clr_note);
	assign drop_waddr = cmd.sw_wr ? sw_q : row_sel;
	assign drop_wdata = cmd.sw_wr ? held_row : (drop_row & ~bit_m);

	hnrr_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_held_ram (
		.clk(clk), .we(held_we), .waddr(row_sel), .wdata(held_row | bit_m),
		.raddr(raddr), .rdata(held_rd)
	);

	hnrr_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_drop_ram (
		.clk(clk), .we(drop_we), .waddr(drop_waddr), .wdata(drop_wdata),
		.raddr(raddr), .rdata(drop_rd)
	);

	hnrr_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_set_ram (
		.clk(clk), .we(set_we), .waddr(row_sel), .wdata(set_row | bit_m),
		.raddr(raddr), .rdata(set_rd)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op;
			ch_q    <= channel;
			key_q   <= key;
			half_q  <= half;
			ph_q    <= playhead;
			pulse_q <= event_pulse;
			stat_q  <= status;
			d1_q    <= data_one;
			d2_q    <= data_two;
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(ph_q) * PPQ_S;
		end
		if (cmd.div_init) begin
			neg_q <= quo[Q_W-1];
			mag_q <= quo[Q_W-1] ? Q_W'(-quo) : Q_W'(quo);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			mag_q <= mag_q << 1;
			if (rem2 >= {1'b0, loop_q}) begin
				rem_q <= LOOP_W'(rem2 - {1'b0, loop_q});
			end else begin
				rem_q <= rem2[LOOP_W-1:0];
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_q     <= '0;
			limit_q    <= LIMIT_RESET;
			held_vld_q <= '0;
			drop_vld_q <= '0;
			set_vld_q  <= '0;
			held_ped_q <= '0;
			drop_ped_q <= '0;
			set_ped_q  <= '0;
			start_q    <= '0;
			wait_q     <= '0;
			reads_q    <= '0;
			over_q     <= 1'b1;
			mask_q     <= '0;
			pedal_q    <= 1'b0;
			now_q      <= 1'b0;
			sw_q       <= '0;
			cnt_q      <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_LOOP_LENGTH: loop_q  <= cfg_data[LOOP_W-1:0];
					REG_SCAN_LIMIT:  limit_q <= cfg_data[LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				mask_q  <= '0;
				pedal_q <= 1'b0;
				now_q   <= 1'b0;
			end
			if (cmd.dec) begin
				case (op_q)
					OP_HOLD_PEDAL: begin
						if (ch_ok) held_ped_q[chi] <= 1'b1;
					end
					OP_CLEAR_HELD: begin
						held_vld_q <= '0;
						held_ped_q <= '0;
					end
					OP_READ: begin
						pedal_q <= ch_ok && drop_ped_q[chi];
					end
					OP_EVENT: begin
						if (ev_go) begin
							reads_q <= reads_nx;
							if (lim_hit) begin
								over_q <= 1'b1;
							end else if (need_rmw) begin
								// note settles in the read-modify-write step
							end else if (ped_cls && ped_pend) begin
								if (d2_q == 8'd0) drop_ped_q[evi] <= 1'b0;
								set_ped_q[evi] <= 1'b1;
								now_q  <= 1'b1;
								wait_q <= wait_dec;
								if (wait_dec == '0) over_q <= 1'b1;
							end else if (wait_q == '0) begin
								over_q <= 1'b1;
							end
						end
					end
					default: ;
				endcase
			end
			if (cmd.rmw) begin
				case (op_q)
					OP_HOLD_NOTE: held_vld_q[row_sel] <= 1'b1;
					OP_READ:      mask_q <= drop_row;
					OP_EVENT: begin
						if (pend_note) begin
							set_vld_q[row_sel] <= 1'b1;
							now_q  <= 1'b1;
							wait_q <= wait_dec;
							if (wait_dec == '0) over_q <= 1'b1;
						end else if (wait_q == '0) begin
							over_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (cmd.div_init) begin
				cnt_q <= CNT_W'(Q_W - 1);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.fix) begin
				start_q    <= start_nx;
				reads_q    <= '0;
				set_vld_q  <= '0;
				set_ped_q  <= '0;
				drop_ped_q <= held_ped_q;
				wait_q     <= WAIT_W'($countones(held_ped_q));
				sw_q       <= '0;
			end
			if (cmd.sw_wr) begin
				drop_vld_q[sw_q] <= 1'b1;
				wait_q <= wait_q + WAIT_W'($countones(held_row));
				sw_q   <= sw_q + ROW_W'(1);
			end
			if (cmd.fin) begin
				over_q <= (wait_q == '0);
			end
		end
	end

	assign release_mask  = mask_q;
	assign pedal_release = pedal_q;
	assign waiting_left  = wait_q;
	assign scan_done     = over_q;
	assign settled_now   = now_q;
endmodule
`default_nettype wire

FILE: rtl/core/hung_note_release_resolver.sv
// Top level of the hung note release resolver.
// Depends on hnrr_pkg, hnrr_ctrl, hnrr_dp (which uses hnrr_ram).
//
// Usage:
//   Items enter on start while busy is low; the fields op, channel, key,
//   half, playhead, event_pulse, status, data_one and data_two are sampled
//   at that edge. Each item yields one result, shown for exactly one cycle
//   with done high: release_mask, pedal_release, waiting_left, scan_done,
//   settled_now. The receiver cannot hold results off.
//   Pedal holds, pedal events, clears and skipped events go from decode
//   straight to the done state; in-range note holds, admitted note events
//   and in-range reads first pass the read-modify-write step on the bitmaps.
//   Busy stays high through the done cycle, so the next item is taken in
//   the cycle after done at the earliest: an item is never taken before
//   the last one is through. A begin item runs decode, multiply, divider
//   setup, Q steps of the bit-serial remainder unit (Q = 35 at 960 pulses
//   per quarter), threshold, a copy sweep of the held rows into the release
//   rows (ROWS = 2 * CHANNELS, a read and a write state each), finish, done.
//   Configuration writes (cfg_we, cfg_index, cfg_data) land at once; write
//   only while idle. Reset clears all bitmaps at once through per-row flags.
`default_nettype none
module hung_note_release_resolver #(
	parameter int CHANNELS           = 16,
	parameter int KEYS               = 128,
	parameter int PULSES_PER_QUARTER = 960
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic [2:0]                             op,
	input  wire logic [3:0]                             channel,
	input  wire logic [6:0]                             key,
	input  wire logic                                   half,
	input  wire logic signed [hnrr_pkg::PLAYHEAD_W-1:0] playhead,
	input  wire logic [hnrr_pkg::PULSE_W-1:0]           event_pulse,
	input  wire logic [7:0]                             status,
	input  wire logic [7:0]                             data_one,
	input  wire logic [7:0]                             data_two,
	output logic                                        done,
	output logic [hnrr_pkg::ROW_BITS-1:0]               release_mask,
	output logic                                        pedal_release,
	output logic [hnrr_pkg::WAIT_W-1:0]                 waiting_left,
	output logic                                        scan_done,
	output logic                                        settled_now,
	input  wire logic                                   cfg_we,
	input  wire logic [hnrr_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [hnrr_pkg::CFG_W-1:0]             cfg_data
);
	import hnrr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequence each item: decode, optional RAM update, begin-scan steps
	hnrr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.cmd(cmd), .sts(sts)
	);

	// hold the bitmaps, scan counters and threshold arithmetic
	hnrr_dp #(
		.CHANNELS(CHANNELS), .KEYS(KEYS), .PULSES_PER_QUARTER(PULSES_PER_QUARTER)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.op(op), .channel(channel), .key(key), .half(half), .playhead(playhead),
		.event_pulse(event_pulse), .status(status), .data_one(data_one),
		.data_two(data_two), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .release_mask(release_mask),
		.pedal_release(pedal_release), .waiting_left(waiting_left),
		.scan_done(scan_done), .settled_now(settled_now)
	);
endmodule
`default_nettype wire

FILE: rtl/core/hnrr_chk.sv
// Port-level checker for the resolver's start/busy/done sequencing.
// Depends on hung_note_release_resolver_defines.svh; bound to the top level.
`default_nettype none
module hnrr_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);
	`include "hung_note_release_resolver_defines.svh"

	`HNRR_ASSERT_IMP(a_done_busy, done, busy, "result strobe while idle")
	`HNRR_ASSERT_NXT(a_accept_busy, start && !busy, busy, "item accepted but not busy")
	`HNRR_ASSERT_NXT(a_accept_no_done, start && !busy, !done, "result too early")
	`HNRR_ASSERT_NXT(a_done_pulse, done, !done && !busy, "result strobe longer than a cycle")
endmodule

bind hung_note_release_resolver hnrr_chk u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done)
);
`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking bench for the hung note release resolver.
// Depends on hnrr_pkg and hung_note_release_resolver; holds its own predictor.
`timescale 1ns / 1ps
module tb_top;
	import hnrr_pkg::*;

	typedef struct packed {
		logic [2:0]  op;
		logic [3:0]  channel;
		logic [6:0]  key;
		logic        half;
		logic [39:0] playhead;
		logic [23:0] event_pulse;
		logic [7:0]  status;
		logic [7:0]  data_one;
		logic [7:0]  data_two;
	} item_t;

	typedef struct packed {
		logic [63:0] mask;
		logic        pedal;
		logic [11:0] waiting;
		logic        over;
		logic        settled;
	} answer_t;

	// A cfg entry in the item queue is flagged by is_cfg; the driver writes it once idle.
	typedef struct {
		bit        is_cfg;
		bit        drain;
		int        gap;
		item_t     it;
		bit [1:0]  idx;
		bit [23:0] val;
	} slot_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [2:0] op = '0;
	logic [3:0] channel = '0;
	logic [6:0] key = '0;
	logic half = 1'b0;
	logic signed [39:0] playhead = '0;
	logic [23:0] event_pulse = '0;
	logic [7:0] status = '0, data_one = '0, data_two = '0;
	logic done;
	logic [63:0] release_mask;
	logic pedal_release;
	logic [11:0] waiting_left;
	logic scan_done, settled_now;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;

	always #10 clk = ~clk;

	hung_note_release_resolver u_dut (.*);

	// predictor state
	logic [127:0] held_rows [16];
	logic [15:0]  held_ped;
	logic [127:0] drop_rows [16];
	logic [15:0]  drop_ped;
	logic [127:0] done_rows [16];
	logic [15:0]  done_ped;
	longint       first_pulse;
	int unsigned  pending_cnt, seen_cnt, loop_len, read_cap;
	bit           sweep_over;

	slot_t   pending_items[$];
	answer_t expected_answers[$];
	int      errors = 0;
	bit      stim_done = 0;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic void predictor_reset();
		for (int c = 0; c < 16; c++) begin
			held_rows[c] = '0; drop_rows[c] = '0; done_rows[c] = '0;
		end
		held_ped = '0; drop_ped = '0; done_ped = '0;
		first_pulse = 0; pending_cnt = 0; seen_cnt = 0; sweep_over = 1;
		loop_len = 0; read_cap = 1024;
	endfunction

	function automatic void begin_sweep(input logic [39:0] raw);
		longint p, span;
		int unsigned w;
		p = longint'($signed(raw)) * 960;
		if (loop_len != 0) begin
			span = longint'(loop_len) * 65536;
			p = p % span;
			if (p < 0) p += span;
		end
		if (p <= 0) first_pulse = 0;
		else begin
			first_pulse = (p + 65535) / 65536;
			if (first_pulse > 16777216) first_pulse = 16777216;
		end
		w = 0;
		for (int c = 0; c < 16; c++) begin
			w += $countones(held_rows[c]);
			drop_rows[c] = held_rows[c];
			done_rows[c] = '0;
		end
		w += $countones(held_ped);
		drop_ped = held_ped; done_ped = '0;
		pending_cnt = w; seen_cnt = 0; sweep_over = (w == 0);
	endfunction

	function automatic bit settle_event(input item_t it);
		logic [3:0] c;
		logic [7:0] kind;
		logic [6:0] n;
		bit hit;
		c = it.status[3:0];
		kind = it.status & KIND_MASK;
		n = it.data_one[6:0];
		hit = 0;
		if (sweep_over || longint'(it.event_pulse) < first_pulse) return 0;
		seen_cnt++;
		if (seen_cnt > read_cap) begin
			sweep_over = 1;
			return 0;
		end
		if (kind == KIND_NOTE_ON || kind == KIND_NOTE_OFF) begin
			if (drop_rows[c][n] && !done_rows[c][n]) begin
				if (kind == KIND_NOTE_OFF || it.data_two == 0) drop_rows[c][n] = 1'b0;
				done_rows[c][n] = 1'b1;
				hit = 1;
			end
		end else if (kind == KIND_CTRL && (it.data_one & DATA_MASK) == CTRL_SUSTAIN) begin
			if (drop_ped[c] && !done_ped[c]) begin
				if (it.data_two == 0) drop_ped[c] = 1'b0;
				done_ped[c] = 1'b1;
				hit = 1;
			end
		end
		if (hit && pending_cnt > 0) pending_cnt--;
		if (pending_cnt == 0) sweep_over = 1;
		return hit;
	endfunction

	function automatic answer_t predict_release(input item_t it);
		answer_t a;
		a = '0;
		case (it.op)
			OP_HOLD_NOTE:  held_rows[it.channel][it.key] = 1'b1;
			OP_HOLD_PEDAL: held_ped[it.channel] = 1'b1;
			OP_BEGIN:      begin_sweep(it.playhead);
			OP_EVENT:      a.settled = settle_event(it);
			OP_READ: begin
				a.mask = it.half ? drop_rows[it.channel][127:64] : drop_rows[it.channel][63:0];
				a.pedal = drop_ped[it.channel];
			end
			OP_CLEAR_HELD: begin
				for (int c = 0; c < 16; c++) held_rows[c] = '0;
				held_ped = '0;
			end
			default: ;
		endcase
		a.waiting = pending_cnt[11:0];
		a.over = sweep_over;
		return a;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	function automatic void push_item(input item_t it);
		slot_t s;
		s = '{default: 0};
		s.it = it;
		s.gap = pick_gap();
		pending_items = {pending_items, s};
	endfunction

	function automatic void push_cfg(input bit [1:0] idx, input bit [23:0] val);
		slot_t s;
		s = '{default: 0};
		s.is_cfg = 1; s.idx = idx; s.val = val;
		pending_items = {pending_items, s};
	endfunction

	function automatic void push_drain();
		slot_t s;
		s = '{default: 0};
		s.drain = 1;
		pending_items = {pending_items, s};
	endfunction

	function automatic item_t rand_item();
		item_t it;
		it.op = 3'($urandom_range(0, 7));
		it.channel = 4'($urandom); it.key = 7'($urandom); it.half = 1'($urandom);
		it.playhead = 40'({$urandom, $urandom});
		it.event_pulse = 24'($urandom); it.status = 8'($urandom);
		it.data_one = 8'($urandom); it.data_two = 8'($urandom);
		return it;
	endfunction

	function automatic item_t mk(input logic [2:0] o);
		item_t it;
		it = rand_item();
		it.op = o;
		return it;
	endfunction

	// Realistic event: mostly note on/off or sustain, on a small channel/key pool.
	function automatic item_t scan_event(input int unsigned pulse);
		item_t it;
		int r;
		it = mk(OP_EVENT);
		it.event_pulse = 24'(pulse);
		r = $urandom_range(0, 9);
		it.status = {(r < 4) ? 4'h9 : (r < 7) ? 4'h8 : (r < 9) ? 4'hb : 4'($urandom),
			4'($urandom_range(0, 3))};
		it.data_one = (it.status[7:4] == 4'hb && $urandom_range(0, 3) != 0) ? 8'd64
			: {1'($urandom), 7'($urandom_range(60, 67))};
		it.data_two = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom);
		return it;
	endfunction

	// Hold a few notes and pedals, begin, feed sorted events, read back, sometimes clear held.
	function automatic void scan_phrase();
		item_t it;
		int unsigned pulse;
		repeat ($urandom_range(1, 8)) begin
			it = mk($urandom_range(0, 3) == 0 ? OP_HOLD_PEDAL : OP_HOLD_NOTE);
			it.channel = 4'($urandom_range(0, 3));
			it.key = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 6'd0} | 7'($urandom_range(60, 67));
			it.key = $urandom_range(0, 1) ? 7'($urandom_range(60, 67)) : it.key;
			push_item(it);
		end
		it = mk(OP_BEGIN);
		it.playhead = 40'($signed($urandom_range(0, 40 * 65536)) - 5 * 65536);
		push_item(it);
		pulse = $urandom_range(0, 400);
		repeat ($urandom_range(4, 14)) begin
			pulse += $urandom_range(0, 60);
			push_item(scan_event(pulse));
		end
		repeat ($urandom_range(1, 3)) begin
			it = mk(OP_READ);
			it.channel = 4'($urandom_range(0, 3));
			push_item(it);
		end
		if ($urandom_range(0, 3) == 0) push_item(mk(OP_CLEAR_HELD));
	endfunction

	// driver
	slot_t cur;
	bit    have_cur = 0;
	int    wait_cnt = 0;
	bit    in_flight = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cfg_we <= 1'b0;
		end else begin
			cfg_we <= 1'b0;
			if (start && !busy) begin
				expected_answers = {expected_answers, predict_release(cur.it)};
				have_cur = 0;
			end
			if (!have_cur && pending_items.size() != 0 && !(start && busy)) begin
				cur = pending_items.pop_front();
				have_cur = 1;
				wait_cnt = cur.gap;
			end
			if (have_cur && cur.is_cfg) begin
				// write only once every result is in and the block has settled
				if (expected_answers.size() == 0 && !busy && !start) begin
					if (wait_cnt < 8) wait_cnt++;
					else begin
						cfg_we <= 1'b1;
						cfg_index <= cur.idx;
						cfg_data <= cur.val;
						if (cur.idx == REG_LOOP_LENGTH) loop_len = cur.val;
						else read_cap = cur.val[15:0];
						have_cur = 0;
					end
				end else wait_cnt = 0;
				start <= 1'b0;
			end else if (have_cur && cur.drain) begin
				if (expected_answers.size() == 0 && !start) have_cur = 0;
				start <= 1'b0;
			end else if (have_cur && wait_cnt > 0) begin
				wait_cnt--;
				start <= 1'b0;
			end else if (have_cur) begin
				start <= 1'b1;
				{op, channel, key, half} <= {cur.it.op, cur.it.channel, cur.it.key, cur.it.half};
				playhead <= cur.it.playhead;
				event_pulse <= cur.it.event_pulse;
				{status, data_one, data_two} <= {cur.it.status, cur.it.data_one, cur.it.data_two};
			end else start <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		answer_t w;
		if (arst_n && done) begin
			if (expected_answers.size() == 0) begin
				report("unexpected result", 64'(waiting_left), 64'd0);
			end else begin
				w = expected_answers.pop_front();
				if (release_mask !== w.mask) report("release_mask", release_mask, w.mask);
				if (pedal_release !== w.pedal)
					report("pedal_release", 64'(pedal_release), 64'(w.pedal));
				if (waiting_left !== w.waiting)
					report("waiting_left", 64'(waiting_left), 64'(w.waiting));
				if (scan_done !== w.over) report("scan_done", 64'(scan_done), 64'(w.over));
				if (settled_now !== w.settled)
					report("settled_now", 64'(settled_now), 64'(w.settled));
			end
		end
	end

	// stimulus and end of run
	int cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		item_t it;
		int quiet;
		predictor_reset();
		// directed: holds at the extremes, begin, events of each kind, reads
		it = mk(OP_HOLD_NOTE); it.channel = 0; it.key = 0; push_item(it);
		it = mk(OP_HOLD_NOTE); it.channel = 15; it.key = 127; push_item(it);
		it = mk(OP_HOLD_NOTE); it.channel = 15; it.key = 63; push_item(it);
		it = mk(OP_HOLD_PEDAL); it.channel = 15; push_item(it);
		it = mk(OP_HOLD_PEDAL); it.channel = 0; push_item(it);
		it = mk(OP_BEGIN); it.playhead = 40'h80_0000_0000; push_item(it);
		// note-off cancels, note-on with zero velocity cancels, note-on keeps
		it = mk(OP_EVENT); it.event_pulse = 0; it.status = 8'h80; it.data_one = 8'h80;
		push_item(it);
		it = mk(OP_EVENT); it.event_pulse = 5; it.status = 8'h9f; it.data_one = 8'hff;
		it.data_two = 0; push_item(it);
		it = mk(OP_EVENT); it.event_pulse = 6; it.status = 8'h9f; it.data_one = 63;
		it.data_two = 8'hff; push_item(it);
		// pedal with value zero cancels; non-sustain controller is ignored
		it = mk(OP_EVENT); it.event_pulse = 7; it.status = 8'hbf; it.data_one = 65;
		push_item(it);
		it = mk(OP_EVENT); it.event_pulse = 8; it.status = 8'hbf; it.data_one = 8'hc0;
		it.data_two = 0; push_item(it);
		it = mk(OP_READ); it.channel = 15; it.half = 1; push_item(it);
		it = mk(OP_READ); it.channel = 0; it.half = 0; push_item(it);
		push_item(mk(3'd6)); push_item(mk(3'd7));
		push_item(mk(OP_CLEAR_HELD));
		it = mk(OP_BEGIN); it.playhead = 40'h7f_ffff_ffff; push_item(it);
		// hold-off until everything drained
		push_drain();
		push_cfg(REG_LOOP_LENGTH, 24'hff_ffff);
		push_cfg(REG_SCAN_LIMIT, 24'd0);
		it = mk(OP_HOLD_NOTE); it.channel = 2; it.key = 64; push_item(it);
		it = mk(OP_BEGIN); it.playhead = 40'h80_0000_0000; push_item(it);
		it = mk(OP_EVENT); it.event_pulse = 24'hff_ffff; push_item(it);
		push_item(mk(OP_EVENT));
		// random phases across several settings
		for (int ph = 0; ph < 6; ph++) begin
			push_cfg(REG_LOOP_LENGTH, (ph == 0) ? 24'd0 : (ph == 1) ? 24'd1
				: 24'($urandom_range(1, 2000)));
			push_cfg(REG_SCAN_LIMIT, (ph == 2) ? 24'd3 : (ph == 5) ? 24'hffff
				: 24'($urandom_range(4, 30)));
			repeat (4) begin
				scan_phrase();
				if ($urandom_range(0, 2) == 0) push_item(rand_item());
			end
		end
		wait (pending_items.size() == 0 && !have_cur && !start);
		quiet = 0;
		while (quiet < 200) begin
			@(posedge clk);
			if (expected_answers.size() == 0) quiet++;
			else quiet = 0;
		end
		if (errors == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

endmodule

FILE: hung_note_release_resolver.f
+incdir+rtl/core
rtl/core/hnrr_pkg.sv
rtl/core/hnrr_ram.sv
rtl/core/hnrr_ctrl.sv
rtl/core/hnrr_dp.sv
rtl/core/hung_note_release_resolver.sv
rtl/core/hnrr_chk.sv
dv/tb_top.sv
